@@ rtl/core/dgml_pkg.sv @@
// shared types and constants for the dg minmod slope limiter
// no dependencies; used by dgml_limit_dir and dg_minmod_slope_limiter
`default_nettype none

package dgml_pkg;

  // field widths
  localparam int unsigned QW       = 32;
  localparam int unsigned ThrW     = 31;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned InDataW  = 7 * QW;
  localparam int unsigned OutDataW = 2 * QW;

  // register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] REG_THR_X = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_THR_Y = 2'd1;

  // signed q16.16 value
  typedef logic signed [QW-1:0] q16_t;

  // input word, last field in the lowest bits
  typedef struct packed {
    q16_t slope_y;
    q16_t slope_x;
    q16_t up_avg;
    q16_t down_avg;
    q16_t right_avg;
    q16_t left_avg;
    q16_t center_avg;
  } in_data_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    q16_t new_slope_y;
    q16_t new_slope_x;
  } out_data_t;

  // per-direction limiter result
  typedef struct packed {
    q16_t slope;
    logic over;
    logic changed;
  } lim_res_t;

endpackage

`default_nettype wire

@@ rtl/core/dgml_limit_dir.sv @@
// tvb minmod limiting of one slope against its two halved neighbor differences
// depends on dgml_pkg
`default_nettype none

module dgml_limit_dir (
  input  wire dgml_pkg::q16_t                slope,
  input  wire dgml_pkg::q16_t                lo,
  input  wire dgml_pkg::q16_t                mid,
  input  wire dgml_pkg::q16_t                hi,
  input  wire logic [dgml_pkg::ThrW-1:0]     thr,
  output dgml_pkg::lim_res_t                 res
);

  logic signed [dgml_pkg::QW:0] d_fwd;
  logic signed [dgml_pkg::QW:0] d_bwd;
  dgml_pkg::q16_t               h_fwd;
  dgml_pkg::q16_t               h_bwd;
  logic [dgml_pkg::QW-1:0]      s_u;
  logic [dgml_pkg::QW-1:0]      s_mag;
  logic                         over;
  logic                         all_pos;
  logic                         all_neg;
  dgml_pkg::q16_t               min_a;
  dgml_pkg::q16_t               min_v;
  dgml_pkg::q16_t               max_a;
  dgml_pkg::q16_t               max_v;
  dgml_pkg::q16_t               lim;

  // exact 33-bit differences, halved with floor rounding
  assign d_fwd = {hi[dgml_pkg::QW-1], hi} - {mid[dgml_pkg::QW-1], mid};
  assign d_bwd = {mid[dgml_pkg::QW-1], mid} - {lo[dgml_pkg::QW-1], lo};
  assign h_fwd = d_fwd[dgml_pkg::QW:1];
  assign h_bwd = d_bwd[dgml_pkg::QW:1];

  // magnitude test, most negative value maps to 2^31
  assign s_u   = slope;
  assign s_mag = slope[dgml_pkg::QW-1] ? (~s_u + {{(dgml_pkg::QW-1){1'b0}}, 1'b1}) : s_u;
  assign over  = s_mag > {1'b0, thr};

  // sign agreement, zero counts as disagreement
  assign all_pos = !slope[dgml_pkg::QW-1] && (slope != '0) &&
                   !h_fwd[dgml_pkg::QW-1] && (h_fwd != '0) &&
                   !h_bwd[dgml_pkg::QW-1] && (h_bwd != '0);
  assign all_neg = slope[dgml_pkg::QW-1] && h_fwd[dgml_pkg::QW-1] && h_bwd[dgml_pkg::QW-1];

  // least magnitude: smallest when positive, largest when negative
  assign min_a = (h_fwd < slope) ? h_fwd : slope;
  assign min_v = (h_bwd < min_a) ? h_bwd : min_a;
  assign max_a = (h_fwd > slope) ? h_fwd : slope;
  assign max_v = (h_bwd > max_a) ? h_bwd : max_a;

  always_comb begin
    if (all_pos) begin
      lim = min_v;
    end else if (all_neg) begin
      lim = max_v;
    end else begin
      lim = '0;
    end
  end

  // apply only above threshold
  assign res.slope   = over ? lim : slope;
  assign res.over    = over;
  assign res.changed = over && (lim != slope);

endmodule

`default_nettype wire

@@ rtl/core/dg_minmod_slope_limiter.sv @@
// tvb minmod slope limiter for 2d dg cells, top level
// path: an accepted input word is held in the input register, then its result in the result register
// throughput: one cell per cycle while out_tready holds, set by the input register and result register pair
// reset (synchronous, rst_n low): both pipeline stages empty, thresholds cleared to 0
// depends on dgml_pkg and dgml_limit_dir
`default_nettype none

module dg_minmod_slope_limiter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [dgml_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [dgml_pkg::ThrW-1:0]         cfg_wdata,
  // input stream
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // center_avg, left_avg, right_avg, down_avg, up_avg, slope_x, slope_y
  input  wire logic [dgml_pkg::InDataW-1:0]      in_tdata,
  // result stream
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // new_slope_x, new_slope_y
  output      logic [dgml_pkg::OutDataW-1:0]     out_tdata,
  // clear_high_order
  output      logic                              out_tuser
);

  logic [dgml_pkg::ThrW-1:0] thr_x_r;
  logic [dgml_pkg::ThrW-1:0] thr_y_r;
  dgml_pkg::in_data_t        s1_data_r;
  logic                      s1_valid_r;
  dgml_pkg::out_data_t       out_data_r;
  logic                      out_flag_r;
  logic                      out_valid_r;
  logic                      s1_adv;
  dgml_pkg::lim_res_t        x_res;
  dgml_pkg::lim_res_t        y_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_x_r <= '0;
      thr_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dgml_pkg::REG_THR_X: thr_x_r <= cfg_wdata;
        dgml_pkg::REG_THR_Y: thr_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= dgml_pkg::in_data_t'(in_tdata);
    end
  end

  // one limiter per direction
  dgml_limit_dir u_lim_x (
    .slope (s1_data_r.slope_x),
    .lo    (s1_data_r.left_avg),
    .mid   (s1_data_r.center_avg),
    .hi    (s1_data_r.right_avg),
    .thr   (thr_x_r),
    .res   (x_res)
  );

  dgml_limit_dir u_lim_y (
    .slope (s1_data_r.slope_y),
    .lo    (s1_data_r.down_avg),
    .mid   (s1_data_r.center_avg),
    .hi    (s1_data_r.up_avg),
    .thr   (thr_y_r),
    .res   (y_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r.new_slope_x <= x_res.slope;
      out_data_r.new_slope_y <= y_res.slope;
      out_flag_r             <= x_res.changed || y_res.changed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

  // a word moved out of the input register shows up as a result word
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("result word lost between stages");

  // an empty input register never stalls the input side
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty input register");

  // the x slope only changes when it exceeds its threshold
  a_change_x: assert property (@(posedge clk) disable iff (!rst_n)
    x_res.changed |-> x_res.over)
    else $error("x slope changed below threshold");

  // a limited nonzero y slope keeps its sign
  a_sign_y: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && y_res.changed && (y_res.slope != '0)) |->
      (y_res.slope[dgml_pkg::QW-1] == s1_data_r.slope_y[dgml_pkg::QW-1]))
    else $error("y slope sign flipped by limiter");

  // reset empties both stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for dg_minmod_slope_limiter
// predicts each cell's limited slopes and clear flag, checks result words in order
// depends on dgml_pkg and the limiter rtl
`default_nettype none

module tb_top;
  import dgml_pkg::*;

  // spare indexes on the configuration port, writes there must be ignored
  localparam logic [CfgAddrW-1:0] REG_SPARE    = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_SPARE_HI = 2'd3;

  localparam q16_t QMAX = 32'sh7FFF_FFFF;
  localparam q16_t QMIN = 32'sh8000_0000;
  localparam logic [ThrW-1:0] THR_MAX = '1;
  localparam logic [ThrW-1:0] THR_NONE = '0;

  // expected result of one cell
  typedef struct packed {
    q16_t nx;
    q16_t ny;
    logic clr;
  } cell_result_t;

  // limited slope of one direction
  typedef struct packed {
    q16_t slope;
    logic changed;
  } axis_result_t;

  typedef enum {AXIS_SMOOTH, AXIS_PEAK, AXIS_FLAT} axis_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [ThrW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic out_tuser;

  // local copy of the thresholds
  logic [ThrW-1:0] thr_x_m = '0;
  logic [ThrW-1:0] thr_y_m = '0;

  cell_result_t pending_q[$];
  int err_count = 0;
  bit gaps_on = 1'b1;
  int stall_left = 0;
  cell_result_t want;
  out_data_t got;

  dg_minmod_slope_limiter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------

  // minmod of the slope against the halved one-sided differences
  function automatic axis_result_t limit_axis(input q16_t s, input q16_t lo, input q16_t mid,
                                              input q16_t hi, input logic [ThrW-1:0] thr);
    logic [32:0] mag;
    logic signed [32:0] fwd;
    logic signed [32:0] bwd;
    logic signed [32:0] fwd_h;
    logic signed [32:0] bwd_h;
    q16_t a;
    q16_t b;
    q16_t m;
    axis_result_t res;
    mag = s[31] ? (~{1'b1, s} + 33'd1) : {1'b0, s};
    if (mag <= {2'b00, thr}) begin
      res.slope = s;
      res.changed = 1'b0;
      return res;
    end
    fwd = $signed({hi[31], hi}) - $signed({mid[31], mid});
    bwd = $signed({mid[31], mid}) - $signed({lo[31], lo});
    // arithmetic shift floors toward minus infinity
    fwd_h = fwd >>> 1;
    bwd_h = bwd >>> 1;
    a = fwd_h[31:0];
    b = bwd_h[31:0];
    m = '0;
    if (s > 0 && a > 0 && b > 0) begin
      m = s;
      if (a < m) m = a;
      if (b < m) m = b;
    end else if (s < 0 && a < 0 && b < 0) begin
      m = s;
      if (a > m) m = a;
      if (b > m) m = b;
    end
    res.slope = m;
    res.changed = (m != s);
    return res;
  endfunction

  function automatic cell_result_t limit_cell(input in_data_t c, input logic [ThrW-1:0] tx,
                                              input logic [ThrW-1:0] ty);
    axis_result_t rx;
    axis_result_t ry;
    cell_result_t res;
    rx = limit_axis(c.slope_x, c.left_avg, c.center_avg, c.right_avg, tx);
    ry = limit_axis(c.slope_y, c.down_avg, c.center_avg, c.up_avg, ty);
    res.nx = rx.slope;
    res.ny = ry.slope;
    res.clr = rx.changed | ry.changed;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // result side: random stalls and in-order checking
  // ---------------------------------------------------------------

  // random stall bursts on the result side
  always @(negedge clk) begin
    if (!rst_n || !gaps_on) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result word with the oldest pending cell
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result word with no cell pending");
        err_count++;
      end else begin
        want = pending_q.pop_front();
        got = out_data_t'(out_tdata);
        if (got.new_slope_x !== want.nx) begin
          $error("new_slope_x: expected %0d actual %0d", want.nx, got.new_slope_x);
          err_count++;
        end
        if (got.new_slope_y !== want.ny) begin
          $error("new_slope_y: expected %0d actual %0d", want.ny, got.new_slope_y);
          err_count++;
        end
        if (out_tuser !== want.clr) begin
          $error("clear_high_order: expected %0b actual %0b", want.clr, out_tuser);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------

  // send one cell word, starting and ending just after a falling edge
  task automatic send_cell(input in_data_t c);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(limit_cell(c, thr_x_m, thr_y_m));
    @(negedge clk);
  endtask

  // stop sending and let the pipeline drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] idx, input logic [ThrW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_THR_X) thr_x_m = val;
    else if (idx == REG_THR_Y) thr_y_m = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [ThrW-1:0] tx, input logic [ThrW-1:0] ty);
    wait_idle();
    cfg_write(REG_THR_X, tx);
    cfg_write(REG_THR_Y, ty);
  endtask

  function automatic in_data_t mk_cell(input q16_t c, input q16_t l, input q16_t r,
                                       input q16_t d, input q16_t u, input q16_t sx,
                                       input q16_t sy);
    in_data_t v;
    v.center_avg = c;
    v.left_avg = l;
    v.right_avg = r;
    v.down_avg = d;
    v.up_avg = u;
    v.slope_x = sx;
    v.slope_y = sy;
    return v;
  endfunction

  // ---------------------------------------------------------------
  // random cell generation
  // ---------------------------------------------------------------

  function automatic int srand(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic q16_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return QMIN;
      1: return QMAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // neighbours and slope for one direction around center c
  function automatic void gen_axis(input int c, output int lo, output int hi, output int s);
    axis_shape_t shape;
    int st;
    int a;
    int b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: shape = AXIS_SMOOTH;
      5, 6, 7: shape = AXIS_PEAK;
      default: shape = AXIS_FLAT;
    endcase
    case (shape)
      AXIS_SMOOTH: begin
        st = srand(1 << 20);
        lo = c - st + srand(1 << 14);
        hi = c + st + srand(1 << 14);
        case ($urandom_range(0, 3))
          0: s = st / 2;
          1: s = st;
          2: s = 2 * st + srand(1 << 10);
          default: s = -st;
        endcase
      end
      AXIS_PEAK: begin
        a = $urandom_range(1, 1 << 20);
        b = $urandom_range(1, 1 << 20);
        if ($urandom_range(0, 1)) begin
          lo = c + a;
          hi = c + b;
        end else begin
          lo = c - a;
          hi = c - b;
        end
        s = srand(1 << 21);
      end
      default: begin
        st = srand(1 << 20);
        if ($urandom_range(0, 1)) begin
          lo = c;
          hi = c + st;
        end else begin
          lo = c - st;
          hi = c;
        end
        s = srand(1 << 21);
      end
    endcase
  endfunction

  function automatic in_data_t gen_cell();
    in_data_t v;
    int c;
    int lo;
    int hi;
    int s;
    case ($urandom_range(0, 9))
      // full-range noise
      0: begin
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      // corners of the number range
      1: begin
        v = mk_cell(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                    pick_extreme(), pick_extreme(), pick_extreme());
      end
      // plausible cell with structured neighbours
      default: begin
        c = srand(1 << 28);
        v.center_avg = c;
        gen_axis(c, lo, hi, s);
        v.left_avg = lo;
        v.right_avg = hi;
        v.slope_x = s;
        gen_axis(c, lo, hi, s);
        v.down_avg = lo;
        v.up_avg = hi;
        v.slope_y = s;
      end
    endcase
    return v;
  endfunction

  function automatic logic [ThrW-1:0] gen_small_thr();
    return ThrW'($urandom_range(0, 1 << 21));
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // thresholds at their reset value of zero
  task automatic test_reset_thresholds();
    send_cell(mk_cell(0, 0, 0, 0, 0, 0, 0));
    send_cell(mk_cell(0, -2, 2, 0, 0, 1, -1));
  endtask

  // extremes of every field, halving of odd and full-range differences
  task automatic test_field_extremes();
    set_thresholds(THR_MAX, THR_MAX);
    send_cell(mk_cell(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
    send_cell(mk_cell(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN));
    send_cell(mk_cell(QMIN, QMAX, QMAX, QMAX, QMAX, QMIN, QMAX));
    set_thresholds(THR_NONE, THR_NONE);
    send_cell(mk_cell(QMAX, QMIN, QMIN, QMIN, QMIN, QMAX, QMIN));
    send_cell(mk_cell(0, QMIN, QMAX, QMAX, QMIN, QMAX, QMIN));
    send_cell(mk_cell(0, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX));
    send_cell(mk_cell(0, 3, -3, -3, 3, -5, -5));
    send_cell(mk_cell(0, -3, 3, 3, -3, 5, 5));
    // a zero difference forces the result to zero
    send_cell(mk_cell(5, 5, 9, 1, 5, 3, -3));
    // slope already the smallest operand
    send_cell(mk_cell(0, -100, 100, 100, -100, 7, -7));
  endtask

  // slope magnitude equal to and just past the bound
  task automatic test_threshold_boundary();
    set_thresholds(ThrW'(100), ThrW'(100));
    send_cell(mk_cell(0, 0, 0, 0, 0, 100, -100));
    send_cell(mk_cell(0, 0, 0, 0, 0, -100, 100));
    send_cell(mk_cell(0, 0, 0, 0, 0, 101, -101));
  endtask

  // writes to indexes past the two registers change nothing
  task automatic test_spare_registers();
    wait_idle();
    cfg_write(REG_SPARE, THR_MAX);
    cfg_write(REG_SPARE_HI, THR_NONE);
    send_cell(mk_cell(0, 0, 0, 0, 0, 100, -101));
    send_cell(mk_cell(0, 0, 0, 0, 0, -101, 100));
  endtask

  // random cells over several threshold settings, with idling
  task automatic test_random_phases();
    logic [ThrW-1:0] tx;
    logic [ThrW-1:0] ty;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin tx = THR_NONE; ty = THR_NONE; end
        1: begin tx = THR_MAX; ty = THR_MAX; end
        2: begin tx = THR_NONE; ty = THR_MAX; end
        3: begin tx = THR_MAX; ty = THR_NONE; end
        4: begin tx = ThrW'($urandom); ty = ThrW'($urandom); end
        default: begin tx = gen_small_thr(); ty = gen_small_thr(); end
      endcase
      set_thresholds(tx, ty);
      for (int i = 0; i < 155; i++) begin
        // stretches without idling now and then
        if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        send_cell(gen_cell());
      end
      gaps_on = 1'b1;
    end
  endtask

  // back-to-back cells with both sides always ready
  task automatic test_steady_stream();
    set_thresholds(gen_small_thr(), gen_small_thr());
    gaps_on = 1'b0;
    for (int i = 0; i < 200; i++) send_cell(gen_cell());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_thresholds();
    test_field_extremes();
    test_threshold_boundary();
    test_spare_registers();
    test_random_phases();
    test_steady_stream();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
